// ===== sv/greedy_min_makespan_path_assigner_top_defines.svh =====
// Assertion macros for the greedy minimum-makespan path assigner.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
// The assertions are compiled out when SYNTHESIS is defined.
`ifndef GREEDY_MIN_MAKESPAN_PATH_ASSIGNER_TOP_DEFINES_SVH
`define GREEDY_MIN_MAKESPAN_PATH_ASSIGNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge outside reset.
`define GMM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define GMM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define GMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GMM_ASSERT(lbl, expr, msg)
`define GMM_ASSERT_IMPL(lbl, ante, cons, msg)
`define GMM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/gmm_pkg.sv =====
// Shared types, constants and helper functions of the path assigner.
// Used by gmm_cell, gmm_ctrl and the top level; depends on nothing.
`default_nettype none

package gmm_pkg;

    // Sizing of the path table.
    localparam int MAX_PATHS = 16;
    localparam int COST_BITS = 12;
    localparam int IDX_W     = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

    // Fixed field widths of the stream payload.
    localparam int CNT_W     = 12;
    localparam int PIU_W     = 5;
    localparam int MS_W      = 16;
    localparam int OUT_IDX_W = 4;
    localparam int REQ_W     = 2;

    // Width of cost plus count, one bit above the wider addend.
    localparam int SUM_BASE  = (COST_BITS > CNT_W) ? COST_BITS : CNT_W;
    localparam int SPAN_W    = SUM_BASE + 1;
    localparam int WIDE_W    = (SPAN_W > MS_W) ? SPAN_W : MS_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam int               SPAN_MAX = 65535;
    localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(16);

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SPAN_W-1:0]    span_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // Request kinds carried in the slave tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ASSIGN = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_UPD,
        ST_RESP
    } state_t;

    // Token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic  valid;
        logic  pass2;
        span_t max1;
        idx_t  idx1;
        span_t max2;
        span_t best;
        idx_t  win;
        logic  found;
        cost_t wcost;
        cnt_t  wcnt;
    } tok_t;

    // Table writes broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             load_en;
        idx_t             load_idx;
        cost_t            load_cost;
        logic             load_reach;
        logic             clear;
        logic             inc_en;
        idx_t             inc_idx;
        logic [PIU_W-1:0] paths_in_use;
    } cell_ctl_t;

    // One more ant, held at the count ceiling.
    function automatic cnt_t bump(input cnt_t c);
        cnt_t r;
        r = (c == CNT_MAX) ? c : c + cnt_t'(1);
        return r;
    endfunction

    // Cost plus count; zero when the cost is zero.
    function automatic span_t span_sum(input cost_t cost, input cnt_t cnt);
        span_t r;
        r = (cost == '0) ? '0 : span_t'(cost) + span_t'(cnt);
        return r;
    endfunction

    // Clamp a span to the width of the makespan field.
    function automatic logic [MS_W-1:0] sat_span(input span_t s);
        logic [WIDE_W-1:0] w;
        logic [MS_W-1:0]   r;
        w = WIDE_W'(s);
        r = (w > WIDE_W'(SPAN_MAX)) ? '1 : MS_W'(w);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gmm_cell.sv =====
// One path entry: cost, reachable mark and ant count, plus one stage of the token row.
// Depends on gmm_pkg for the token and control types.
`default_nettype none

module gmm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gmm_pkg::idx_t     cell_idx,
    input  wire gmm_pkg::cell_ctl_t ctl,
    input  wire gmm_pkg::tok_t     tok_in,
    output gmm_pkg::tok_t          tok_out
);

    gmm_pkg::cost_t cost_reg, cost_next;
    logic           reach_reg, reach_next;
    gmm_pkg::cnt_t  cnt_reg, cnt_next;
    gmm_pkg::tok_t  tok_reg, tok_next;

    logic           active;
    gmm_pkg::span_t s_base;
    gmm_pkg::span_t s_trial;
    gmm_pkg::span_t other;
    gmm_pkg::span_t trial;

    // Table writes for this entry.
    always_comb
    begin
        cost_next  = cost_reg;
        reach_next = reach_reg;
        cnt_next   = cnt_reg;
        if (ctl.load_en && (ctl.load_idx == cell_idx))
        begin
            cost_next  = ctl.load_cost;
            reach_next = ctl.load_reach;
        end
        priority if (ctl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.inc_en && (ctl.inc_idx == cell_idx))
        begin
            cnt_next = gmm_pkg::bump(cnt_reg);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Spans this entry contributes, now and with one more ant.
    assign active  = (32'(cell_idx) < 32'(ctl.paths_in_use));
    assign s_base  = (cnt_reg == '0) ? '0 : gmm_pkg::span_sum(cost_reg, cnt_reg);
    assign s_trial = gmm_pkg::span_sum(cost_reg, gmm_pkg::bump(cnt_reg));
    assign other   = (tok_in.idx1 == cell_idx) ? tok_in.max2 : tok_in.max1;
    assign trial   = (s_trial > other) ? s_trial : other;

    // Token update: the first pass keeps the two largest spans, the second picks the winner.
    always_comb
    begin
        tok_next = tok_in;
        // Entry zero takes the ant when no entry is reachable, even outside the window.
        if (tok_in.valid && tok_in.pass2 && (cell_idx == '0))
        begin
            tok_next.wcost = cost_reg;
            tok_next.wcnt  = cnt_reg;
        end
        if (tok_in.valid && active)
        begin
            if (!tok_in.pass2)
            begin
                if (s_base > tok_in.max1)
                begin
                    tok_next.max2 = tok_in.max1;
                    tok_next.max1 = s_base;
                    tok_next.idx1 = cell_idx;
                end
                else if (s_base > tok_in.max2)
                begin
                    tok_next.max2 = s_base;
                end
            end
            else
            begin
                if (reach_reg && (!tok_in.found || (trial < tok_in.best)))
                begin
                    tok_next.best  = trial;
                    tok_next.win   = cell_idx;
                    tok_next.found = 1'b1;
                    tok_next.wcost = cost_reg;
                    tok_next.wcnt  = cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg  <= '0;
            reach_reg <= 1'b0;
            cnt_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            cost_reg  <= cost_next;
            reach_reg <= reach_next;
            cnt_reg   <= cnt_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== sv/gmm_ctrl.sv =====
// Sequencer of the path assigner: handshakes, configuration, token launch and result.
// Depends on gmm_pkg and the assertion macros in the defines header.
`default_nettype none

`include "greedy_min_makespan_path_assigner_top_defines.svh"

module gmm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Slave side: tuser = req_type; tdata = path_index, path_cost, path_reachable.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    // Master side: tdata = chosen_path, makespan, new_count; tuser = no_path.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tuser,
    // paths_in_use register.
    input  wire logic                 cfg_we,
    input  wire logic [4:0]           cfg_wdata,
    // Token row and table control.
    output gmm_pkg::tok_t             head,
    input  wire gmm_pkg::tok_t        tail,
    output gmm_pkg::cell_ctl_t        ctl
);

    gmm_pkg::state_t state_reg, state_next;
    logic [gmm_pkg::PIU_W-1:0] piu_reg, piu_next;
    gmm_pkg::tok_t hold_reg, hold_next;

    logic [gmm_pkg::OUT_IDX_W-1:0] res_path_reg, res_path_next;
    logic [gmm_pkg::MS_W-1:0]      res_span_reg, res_span_next;
    gmm_pkg::cnt_t                 res_cnt_reg, res_cnt_next;
    logic                          res_nopath_reg, res_nopath_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;

    logic            accept;
    gmm_pkg::req_t   req;
    logic [3:0]      in_idx;
    logic [11:0]     in_cost;
    logic            in_reach;
    logic            out_space;

    gmm_pkg::span_t  other_win;
    gmm_pkg::cnt_t   new_cnt;
    gmm_pkg::span_t  s_new;
    gmm_pkg::span_t  span_final;

    // Input unpacking.
    assign req      = gmm_pkg::req_t'(s_tuser);
    assign in_idx   = s_tdata[3:0];
    assign in_cost  = s_tdata[15:4];
    assign in_reach = s_tdata[16];
    assign s_tready = (state_reg == gmm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_space = !out_valid_reg || m_tready;

    // Configuration register.
    assign piu_next = cfg_we ? cfg_wdata : piu_reg;

    // Broadcast table writes.
    always_comb
    begin
        ctl              = '0;
        ctl.load_en      = accept && (req == gmm_pkg::REQ_LOAD) &&
                           (32'(in_idx) < 32'(gmm_pkg::MAX_PATHS));
        ctl.load_idx     = gmm_pkg::idx_t'(in_idx);
        ctl.load_cost    = gmm_pkg::cost_t'(in_cost);
        ctl.load_reach   = in_reach;
        ctl.clear        = accept && (req == gmm_pkg::REQ_CLEAR);
        ctl.inc_en       = (state_reg == gmm_pkg::ST_UPD);
        ctl.inc_idx      = hold_reg.win;
        ctl.paths_in_use = piu_reg;
    end

    // Result of an assign, worked out from the token of the second pass.
    assign other_win  = (hold_reg.idx1 == hold_reg.win) ? hold_reg.max2 : hold_reg.max1;
    assign new_cnt    = gmm_pkg::bump(hold_reg.wcnt);
    assign s_new      = gmm_pkg::span_sum(hold_reg.wcost, new_cnt);
    assign span_final = (piu_reg == '0) ? '0 :
                        ((s_new > other_win) ? s_new : other_win);

    // Next state, token launch and result capture.
    always_comb
    begin
        state_next      = state_reg;
        hold_next       = hold_reg;
        head            = '0;
        res_path_next   = res_path_reg;
        res_span_next   = res_span_reg;
        res_cnt_next    = res_cnt_reg;
        res_nopath_next = res_nopath_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        unique case (state_reg)
            gmm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_path_next   = '0;
                    res_span_next   = '0;
                    res_cnt_next    = '0;
                    res_nopath_next = 1'b0;
                    if (req == gmm_pkg::REQ_ASSIGN)
                    begin
                        head.valid = 1'b1;
                        state_next = gmm_pkg::ST_PASS1;
                    end
                    else
                    begin
                        state_next = gmm_pkg::ST_RESP;
                    end
                end
            end
            gmm_pkg::ST_PASS1:
            begin
                if (tail.valid)
                begin
                    head       = tail;
                    head.pass2 = 1'b1;
                    head.best  = '0;
                    head.win   = '0;
                    head.found = 1'b0;
                    head.wcost = '0;
                    head.wcnt  = '0;
                    state_next = gmm_pkg::ST_PASS2;
                end
            end
            gmm_pkg::ST_PASS2:
            begin
                if (tail.valid)
                begin
                    hold_next  = tail;
                    state_next = gmm_pkg::ST_UPD;
                end
            end
            gmm_pkg::ST_UPD:
            begin
                res_path_next   = gmm_pkg::OUT_IDX_W'(hold_reg.win);
                res_span_next   = gmm_pkg::sat_span(span_final);
                res_cnt_next    = new_cnt;
                res_nopath_next = !hold_reg.found;
                state_next      = gmm_pkg::ST_RESP;
            end
            gmm_pkg::ST_RESP:
            begin
                if (out_space)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_cnt_reg, res_span_reg, res_path_reg};
                    out_user_next  = res_nopath_reg;
                    state_next     = gmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmm_pkg::ST_IDLE;
            piu_reg       <= gmm_pkg::PIU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            piu_reg       <= piu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg       <= hold_next;
        res_path_reg   <= res_path_next;
        res_span_reg   <= res_span_next;
        res_cnt_reg    <= res_cnt_next;
        res_nopath_reg <= res_nopath_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // No token may come out of the row while nothing is in flight.
    `GMM_ASSERT(a_idle_no_token, !((state_reg == gmm_pkg::ST_IDLE) && tail.valid), "token left the row while idle")
    // With no reachable path the ant must go to entry zero.
    `GMM_ASSERT_IMPL(a_nopath_zero, (state_reg == gmm_pkg::ST_UPD) && !hold_reg.found, hold_reg.win == '0, "no-path assign chose a nonzero entry")
    // An assign always leaves the chosen entry with at least one ant.
    `GMM_ASSERT_NEXT(a_count_nonzero, state_reg == gmm_pkg::ST_UPD, res_cnt_reg != '0, "assign produced a zero count")

endmodule

`default_nettype wire

// ===== sv/greedy_min_makespan_path_assigner_top.sv =====
// An assign walks the token through the row of path cells twice, one cell a cycle,
// then passes an update state and a response state that waits for output space and
// registers m_tvalid; s_tready stays low until then and rises together with m_tvalid.
// Load, clear and the unused request go straight from idle to the response state.
// Reset (rst_n low, asynchronous) zeroes every cost, reachable mark and count at once
// and sets paths_in_use to 16; no clearing pass follows.
`default_nettype none

module greedy_min_makespan_path_assigner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave side: tuser = req_type[1:0]; tdata = path_index[3:0], path_cost[15:4],
    // path_reachable[16], zero fill above.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    // Master side: tdata = chosen_path[3:0], makespan[19:4], new_count[31:20];
    // tuser = no_path.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tuser,
    // paths_in_use register write.
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);

    gmm_pkg::tok_t      chain [0:gmm_pkg::MAX_PATHS];
    gmm_pkg::cell_ctl_t ctl;

    // Sequencer.
    gmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (chain[0]),
        .tail      (chain[gmm_pkg::MAX_PATHS]),
        .ctl       (ctl)
    );

    // Row of path cells, each passing the token to the next.
    for (genvar k = 0; k < gmm_pkg::MAX_PATHS; k++)
    begin : g_cell
        gmm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (gmm_pkg::idx_t'(k)),
            .ctl      (ctl),
            .tok_in   (chain[k]),
            .tok_out  (chain[k+1])
        );
    end

endmodule

`default_nettype wire
